// ===== sv/kmd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types, sizes and helpers of the key matrix debouncer.
// ----------------------------------------------------------------------------
package kmd_pkg;

	localparam int unsigned NUM_ROWS = 8;
	localparam int unsigned NUM_COLS = 16;

	localparam int unsigned ROW_W   = 8;
	localparam int unsigned COL_W   = 4;
	localparam int unsigned QROW_W  = 3;
	localparam int unsigned SCAN_W  = 8;
	localparam int unsigned KCNT_W  = 8;
	localparam int unsigned POP_W   = $clog2(ROW_W + 1);
	localparam int unsigned COUNT_W = $clog2(NUM_ROWS * NUM_COLS + 1);

	localparam logic [ROW_W-1:0]   ROW_MASK      = ROW_W'((1 << NUM_ROWS) - 1);
	localparam logic [SCAN_W-1:0]  SCANS_RESET   = SCAN_W'(5);
	localparam logic [COUNT_W-1:0] KEY_COUNT_MAX = COUNT_W'(128);

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row_bits;
		logic              end_of_scan;
		logic [QROW_W-1:0] query_row;
	} kmd_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  stable_rows;
		logic              key_on;
		logic              settled;
		logic [KCNT_W-1:0] key_count;
	} kmd_result_t;

	function automatic logic [POP_W-1:0] kmd_popcount(input logic [ROW_W-1:0] v);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < ROW_W; i++) begin
			n = n + POP_W'(v[i]);
		end
		return n;
	endfunction

endpackage

// ===== sv/kmd_store.sv =====
// ----------------------------------------------------------------------------
// kmd_store
// Pending and stable column stores, quiet counter and running key counts.
// Computes the result of the registered item and updates state on advance.
// ----------------------------------------------------------------------------
module kmd_store import kmd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  kmd_item_t          item,
	input  logic [SCAN_W-1:0]  debounce_scans,
	output kmd_result_t        result
);

	logic [ROW_W-1:0]   pending_q [NUM_COLS];
	logic [ROW_W-1:0]   stable_q  [NUM_COLS];
	logic [SCAN_W-1:0]  quiet_q;
	logic [COUNT_W-1:0] pend_count_q;
	logic [COUNT_W-1:0] stable_count_q;

	logic               col_ok;
	logic [ROW_W-1:0]   rows;
	logic [ROW_W-1:0]   pend_old;
	logic               reload;
	logic [SCAN_W-1:0]  quiet_mid;
	logic               tick;
	logic               copy;
	logic [SCAN_W-1:0]  quiet_next;
	logic [COUNT_W-1:0] pend_count_next;
	logic [COUNT_W-1:0] stable_count_next;
	logic [ROW_W-1:0]   srows;

	always_comb begin
		col_ok   = 32'(item.column) < NUM_COLS;
		rows     = item.row_bits & ROW_MASK;
		pend_old = pending_q[item.column];
		reload   = col_ok && (pend_old != rows);

		if (reload) begin
			quiet_mid = (debounce_scans != '0) ? debounce_scans : SCAN_W'(1);
		end else begin
			quiet_mid = quiet_q;
		end

		tick       = item.end_of_scan && (quiet_mid != '0);
		copy       = tick && (quiet_mid == SCAN_W'(1));
		quiet_next = tick ? quiet_mid - SCAN_W'(1) : quiet_mid;

		if (reload) begin
			pend_count_next = pend_count_q - COUNT_W'(kmd_popcount(pend_old))
				+ COUNT_W'(kmd_popcount(rows));
		end else begin
			pend_count_next = pend_count_q;
		end
		stable_count_next = copy ? pend_count_next : stable_count_q;

		if (!col_ok) begin
			srows = '0;
		end else if (copy) begin
			srows = rows;
		end else begin
			srows = stable_q[item.column];
		end

		result.stable_rows = srows;
		result.key_on      = (32'(item.query_row) < NUM_ROWS) ? srows[item.query_row] : 1'b0;
		result.settled     = (quiet_next == '0);
		result.key_count   = KCNT_W'((stable_count_next > KEY_COUNT_MAX) ? KEY_COUNT_MAX
			: stable_count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q        <= SCANS_RESET;
			pend_count_q   <= '0;
			stable_count_q <= '0;
		end else if (advance) begin
			quiet_q        <= quiet_next;
			pend_count_q   <= pend_count_next;
			stable_count_q <= stable_count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COLS; i++) begin
				pending_q[i] <= '0;
				stable_q[i]  <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < NUM_COLS; i++) begin
				if (reload && (32'(item.column) == i)) begin
					pending_q[i] <= rows;
				end
				if (copy) begin
					stable_q[i] <= (reload && (32'(item.column) == i)) ? rows : pending_q[i];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_quiet_holds_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(quiet_q == '0) && !(advance && reload) |=> (quiet_q == '0))
		else $error("quiet counter left zero without a reload");

	a_copy_settles: assert property (@(posedge clk) disable iff (!arst_n)
		advance && copy |=> (quiet_q == '0) && (stable_count_q == pend_count_q))
		else $error("copy to stable did not settle state");

	a_reload_unsettles: assert property (@(posedge clk) disable iff (!arst_n)
		advance && reload && !item.end_of_scan |=> (quiet_q != '0))
		else $error("reload without tick left counter zero");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(pend_count_q) <= NUM_ROWS * NUM_COLS)
		&& (32'(stable_count_q) <= NUM_ROWS * NUM_COLS))
		else $error("key count beyond matrix size");
`endif

endmodule

// ===== sv/key_matrix_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// key_matrix_debouncer_core
// Debounces sampled key matrix columns and reports stable key state.
//
//  channel | signals                                         | dir
//  in      | in_valid in_ready column row_bits end_of_scan   | request in
//          | query_row                                       |
//  out     | out_valid out_ready stable_rows key_on settled  | request out
//          | key_count                                       |
//  cfg     | cfg_valid cfg_ready cfg_data (debounce_scans)   | write in
//
// One request per cycle sustained unless the result stalls; each request
// passes the input register, then the state update into the result register.
// Reset clears both column stores and loads the quiet counter and the
// debounce count with 5. A stalled result holds the input register, which
// then holds in_ready low. cfg_ready is always high.
// ----------------------------------------------------------------------------
module key_matrix_debouncer_core import kmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [COL_W-1:0]  column,
	input  logic [ROW_W-1:0]  row_bits,
	input  logic              end_of_scan,
	input  logic [QROW_W-1:0] query_row,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROW_W-1:0]  stable_rows,
	output logic              key_on,
	output logic              settled,
	output logic [KCNT_W-1:0] key_count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SCAN_W-1:0] cfg_data
);

	logic [SCAN_W-1:0] debounce_scans_q;
	logic              valid_s1;
	kmd_item_t         item_s1;
	logic              valid_s2;
	kmd_result_t       result_s2;
	kmd_result_t       result;
	logic              advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_scans_q <= SCANS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_scans_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.column      <= column;
			item_s1.row_bits    <= row_bits;
			item_s1.end_of_scan <= end_of_scan;
			item_s1.query_row   <= query_row;
		end
	end

	kmd_store u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.item           (item_s1),
		.debounce_scans (debounce_scans_q),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign stable_rows = result_s2.stable_rows;
	assign key_on      = result_s2.key_on;
	assign settled     = result_s2.settled;
	assign key_count   = result_s2.key_count;

endmodule

// ===== verif/tb_key_matrix_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// tb_key_matrix_debouncer_core
// Self-checking bench for the key matrix debouncer: a burst driver feeds
// column samples, a stalling monitor compares each result field by field
// against an in-bench debounce predictor, across several debounce settings.
// ----------------------------------------------------------------------------
module tb_key_matrix_debouncer_core import kmd_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_EVERY_FOURTH,
		READY_SPARSE
	} ready_pattern_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [COL_W-1:0]  column      = '0;
	logic [ROW_W-1:0]  row_bits    = '0;
	logic              end_of_scan = 1'b0;
	logic [QROW_W-1:0] query_row   = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [ROW_W-1:0]  stable_rows;
	logic              key_on;
	logic              settled;
	logic [KCNT_W-1:0] key_count;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [SCAN_W-1:0] cfg_data    = '0;

	kmd_item_t   sample_queue[$];
	kmd_result_t result_expect[$];
	kmd_item_t   cur_sample;

	logic [ROW_W-1:0]  pend_cols [NUM_COLS];
	logic [ROW_W-1:0]  stab_cols [NUM_COLS];
	logic [SCAN_W-1:0] quiet_cnt = SCANS_RESET;
	logic [SCAN_W-1:0] scans_cfg = SCANS_RESET;
	logic [ROW_W-1:0]  scan_matrix [NUM_COLS];

	int unsigned    burst_left = 0;
	int unsigned    gap_left   = 0;
	int unsigned    stall_left = 0;
	logic [1:0]     cycle_cnt  = '0;
	ready_pattern_t stall_mode = READY_ALWAYS;
	int unsigned    mismatch_count = 0;

	key_matrix_debouncer_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.column      (column),
		.row_bits    (row_bits),
		.end_of_scan (end_of_scan),
		.query_row   (query_row),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.stable_rows (stable_rows),
		.key_on      (key_on),
		.settled     (settled),
		.key_count   (key_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		for (int i = 0; i < NUM_COLS; i++) begin
			pend_cols[i] = '0;
			stab_cols[i] = '0;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t ns] mismatch: %s", $time, msg);
	endtask

	function automatic kmd_result_t predict_debounce(input kmd_item_t s);
		kmd_result_t      r;
		logic [ROW_W-1:0] rows;
		int unsigned      total;
		r = '0;
		rows = s.row_bits & ROW_MASK;
		if (s.column < NUM_COLS && pend_cols[s.column] != rows) begin
			pend_cols[s.column] = rows;
			quiet_cnt = (scans_cfg != '0) ? scans_cfg : SCAN_W'(1);
		end
		if (s.end_of_scan && quiet_cnt != '0) begin
			quiet_cnt = quiet_cnt - 1'b1;
			if (quiet_cnt == '0) begin
				for (int i = 0; i < NUM_COLS; i++)
					stab_cols[i] = pend_cols[i];
			end
		end
		if (s.column < NUM_COLS) begin
			r.stable_rows = stab_cols[s.column];
			if (s.query_row < NUM_ROWS)
				r.key_on = stab_cols[s.column][s.query_row];
		end
		r.settled = (quiet_cnt == '0);
		total = 0;
		for (int i = 0; i < NUM_COLS; i++)
			total += $countones(stab_cols[i]);
		if (total > KEY_COUNT_MAX)
			total = KEY_COUNT_MAX;
		r.key_count = KCNT_W'(total);
		return r;
	endfunction

	// sender: bursts of requests separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				result_expect.push_back(predict_debounce(cur_sample));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					cur_sample = sample_queue.pop_front();
					column      <= cur_sample.column;
					row_bits    <= cur_sample.row_bits;
					end_of_scan <= cur_sample.end_of_scan;
					query_row   <= cur_sample.query_row;
					in_valid    <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(60, 1);
						gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check results, stall on a changing pattern
	always @(posedge clk) begin
		kmd_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_expect.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = result_expect.pop_front();
					if (stable_rows !== want.stable_rows)
						report_mismatch($sformatf("stable_rows got %h want %h",
							stable_rows, want.stable_rows));
					if (key_on !== want.key_on)
						report_mismatch($sformatf("key_on got %b want %b",
							key_on, want.key_on));
					if (settled !== want.settled)
						report_mismatch($sformatf("settled got %b want %b",
							settled, want.settled));
					if (key_count !== want.key_count)
						report_mismatch($sformatf("key_count got %0d want %0d",
							key_count, want.key_count));
				end
			end
			if (stall_left == 0) begin
				stall_mode = ready_pattern_t'($urandom_range(3, 0));
				stall_left = $urandom_range(200, 20);
			end else begin
				stall_left--;
			end
			cycle_cnt = cycle_cnt + 1'b1;
			case (stall_mode)
				READY_ALWAYS:       out_ready <= 1'b1;
				READY_COIN:         out_ready <= 1'($urandom_range(1, 0));
				READY_EVERY_FOURTH: out_ready <= (cycle_cnt == 2'd0);
				default:            out_ready <= ($urandom_range(9, 0) == 0);
			endcase
		end
	end

	task automatic add_sample(input int unsigned col, input logic [ROW_W-1:0] rows,
			input logic eos, input int unsigned qrow);
		kmd_item_t s;
		s.column      = COL_W'(col);
		s.row_bits    = rows;
		s.end_of_scan = eos;
		s.query_row   = QROW_W'(qrow);
		sample_queue.push_back(s);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (sample_queue.size() != 0 || in_valid || result_expect.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_debounce_scans(input logic [SCAN_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		scans_cfg = value;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_scans(input int unsigned n_items, input int unsigned change_pct,
			input int unsigned noise_pct, input int unsigned max_scan);
		int unsigned pushed;
		int unsigned len;
		int unsigned first;
		int unsigned flip_col;
		int unsigned flip_row;
		kmd_item_t   s;
		pushed = 0;
		for (int c = 0; c < NUM_COLS; c++)
			scan_matrix[c] = ROW_W'($urandom);
		while (pushed < n_items) begin
			if ($urandom_range(99, 0) < change_pct) begin
				flip_col = $urandom_range(NUM_COLS - 1, 0);
				flip_row = $urandom_range(ROW_W - 1, 0);
				scan_matrix[flip_col][flip_row] = ~scan_matrix[flip_col][flip_row];
			end
			len = $urandom_range(max_scan, 1);
			first = (len >= NUM_COLS) ? 0 : $urandom_range(NUM_COLS - 1, 0);
			for (int k = 0; k < len && pushed < n_items; k++) begin
				if ($urandom_range(99, 0) < noise_pct) begin
					s = 16'($urandom);
				end else begin
					s.column      = COL_W'((first + k) % NUM_COLS);
					s.row_bits    = scan_matrix[s.column];
					s.end_of_scan = (k == len - 1);
					s.query_row   = QROW_W'($urandom);
				end
				sample_queue.push_back(s);
				pushed++;
			end
		end
	endtask

	task automatic run_phase(input logic [SCAN_W-1:0] scans, input int unsigned n_items,
			input int unsigned change_pct, input int unsigned noise_pct,
			input int unsigned max_scan);
		write_debounce_scans(scans);
		queue_scans(n_items, change_pct, noise_pct, max_scan);
		wait_idle();
	endtask

	initial begin
		#5_000_000;
		$display("key_matrix_debouncer_core regression: fail");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset debounce count: quiet tick, change, then settle over five scans
		add_sample(0, 8'h00, 1'b1, 0);
		add_sample(15, 8'hFF, 1'b0, 7);
		for (int i = 0; i < 5; i++)
			add_sample(15, 8'hFF, 1'b1, (i % 2) ? 0 : 7);
		add_sample(15, 8'h01, 1'b1, 0);
		wait_idle();

		// fill the whole matrix so the key count reaches its maximum
		write_debounce_scans(8'd1);
		for (int c = 0; c < NUM_COLS; c++)
			add_sample(c, 8'hFF, c == NUM_COLS - 1, c % NUM_ROWS);
		wait_idle();

		// zero count still settles on the next end of scan
		write_debounce_scans(8'd0);
		add_sample(3, 8'h5A, 1'b1, 1);
		add_sample(3, 8'h5A, 1'b0, 6);
		wait_idle();

		run_phase(8'd255, 400, 0, 0, 1);
		run_phase(8'd0, 240, 30, 10, 16);
		run_phase(8'd1, 240, 20, 10, 16);
		run_phase(8'd2, 200, 10, 5, 4);
		run_phase(8'($urandom_range(20, 3)), 200, 5, 5, 16);
		run_phase(8'd128, 150, 40, 20, 16);
		run_phase(8'd5, 200, 5, 5, 4);

		repeat (10) @(posedge clk);
		if (result_expect.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", result_expect.size()));
		if (mismatch_count == 0)
			$display("key_matrix_debouncer_core regression: pass");
		else
			$display("key_matrix_debouncer_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/kmd_pkg.sv
sv/kmd_store.sv
sv/key_matrix_debouncer_core.sv
verif/tb_key_matrix_debouncer_core.sv
